@@ rtl/core/vgis_pkg.sv @@
// Shared types and constants for the vector generator instruction step.
`timescale 1ns / 1ps

package vgis_pkg;

   localparam int WORD_W  = 16;
   localparam int COORD_W = 16;
   localparam int BEAM_W  = 32;
   localparam int RAW_W   = 11;   // sign plus ten magnitude bits of a vector delta
   localparam int ABS_W   = 12;   // absolute position fields

   // opcodes, top nibble of the first word
   localparam logic [3:0] OP_HALT0      = 4'h0;
   localparam logic [3:0] OP_LONG_FIRST = 4'h1;
   localparam logic [3:0] OP_LONG_LAST  = 4'h9;
   localparam logic [3:0] OP_ABS        = 4'hA;
   localparam logic [3:0] OP_HALT1      = 4'hB;
   localparam logic [3:0] OP_CALL       = 4'hC;
   localparam logic [3:0] OP_RET        = 4'hD;
   localparam logic [3:0] OP_JUMP       = 4'hE;
   localparam logic [3:0] OP_SHORT      = 4'hF;

   localparam logic [15:0] VEC_BASE    = 16'h4000;
   localparam logic [15:0] TARGET_MASK = 16'h1fff;
   localparam logic [15:0] WORD_BYTES  = 16'h0002;

   localparam logic [3:0] MAX_SCALE        = 4'd9;
   localparam logic [3:0] SHORT_SCALE_BIAS = 4'h2;
   localparam logic [3:0] INTENSITY_LOW    = 4'hf;

   localparam int ABS_Y_FLIP   = 1023;
   localparam int ABS_Y_ORIGIN = 870;

   typedef enum logic [1:0] {
      ST_RUN       = 2'd0,
      ST_HALT      = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] first_word;
      logic [WORD_W-1:0] second_word;
      logic              new_frame;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]         next_address;
      logic                      draw;
      logic                      point_only;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [7:0]                intensity;
      status_type                status;
   } rsp_type;

   // program flow results
   typedef struct packed {
      logic [WORD_W-1:0] next_address;
      status_type        status;
   } flow_type;

   // beam segment results
   typedef struct packed {
      logic                      draw;
      logic                      point_only;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [7:0]                intensity;
   } draw_type;

endpackage

@@ rtl/core/vector_generator_instruction_step.sv @@
// Top level of the vector generator instruction step.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  vgis_pkg::req_type
//   rsp_     out        rsp_valid / rsp_stall  vgis_pkg::rsp_type
//
// A request is registered on entry, then executed against the program counter,
// return stack, scale and beam and written into the result register.
// One request per cycle is sustained while the result side does not stall, set
// by the single execute stage that updates all state.
// Synchronous reset puts the counter at the vector base and clears stack pointer,
// scale and beam. A stalled result holds the execute stage, and the input
// register then stalls the request side.
`timescale 1ns / 1ps

module vector_generator_instruction_step #(
   parameter int STACK_DEPTH   = 4,
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vgis_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vgis_pkg::rsp_type rsp_data
);

   logic              in_valid_ff, in_valid_in;
   vgis_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   vgis_pkg::rsp_type out_data_ff, out_data_in;
   logic              exec;

   vgis_pkg::flow_type flow;
   vgis_pkg::draw_type seg;

   // execute when there is a request and the result slot is free or draining
   assign exec      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !exec;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      out_valid_in = exec ? 1'b1 : (out_valid_ff && rsp_stall);
      out_data_in.next_address = flow.next_address;
      out_data_in.status       = flow.status;
      out_data_in.draw         = seg.draw;
      out_data_in.point_only   = seg.point_only;
      out_data_in.start_x      = seg.start_x;
      out_data_in.start_y      = seg.start_y;
      out_data_in.end_x        = seg.end_x;
      out_data_in.end_y        = seg.end_y;
      out_data_in.intensity    = seg.intensity;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (exec) begin
         out_data_ff <= out_data_in;
      end
   end

   vgis_flow #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_flow (
      .clock(clock),
      .reset(reset),
      .exec (exec),
      .req  (in_data_ff),
      .flow (flow)
   );

   vgis_beam #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_beam (
      .clock(clock),
      .reset(reset),
      .exec (exec),
      .req  (in_data_ff),
      .seg  (seg)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ rtl/core/vgis_flow.sv @@
// Program counter, return stack and halt, overflow and underflow status.
`timescale 1ns / 1ps

module vgis_flow #(
   parameter int STACK_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               exec,
   input  vgis_pkg::req_type  req,
   output vgis_pkg::flow_type flow
);

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [15:0]     pc_ff, pc_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [15:0]     stack_mem [STACK_DEPTH];

   logic [3:0]      opcode;
   logic [15:0]     pc_base, pc_adv, target, pop_data;
   logic [SP_W-1:0] sp_cur;
   logic            push;
   vgis_pkg::status_type status;

   assign opcode = req.first_word[15:12];
   assign target = vgis_pkg::VEC_BASE + ((req.first_word & vgis_pkg::TARGET_MASK) << 1);

   always_comb begin
      pc_base = req.new_frame ? vgis_pkg::VEC_BASE : pc_ff;
      sp_cur  = req.new_frame ? '0 : sp_ff;
      // two-word instructions advance twice
      pc_adv  = (opcode <= vgis_pkg::OP_ABS) ? pc_base + (vgis_pkg::WORD_BYTES << 1)
                                             : pc_base + vgis_pkg::WORD_BYTES;
      pop_data = stack_mem[IDX_W'(sp_cur - SP_W'(1))];
      pc_in  = pc_adv;
      sp_in  = sp_cur;
      push   = 1'b0;
      status = vgis_pkg::ST_RUN;
      case (opcode)
         vgis_pkg::OP_HALT0, vgis_pkg::OP_HALT1: begin
            status = vgis_pkg::ST_HALT;
         end
         vgis_pkg::OP_CALL: begin
            if (sp_cur >= SP_W'(STACK_DEPTH)) begin
               status = vgis_pkg::ST_OVERFLOW;
               sp_in  = '0;
            end else begin
               push  = 1'b1;
               sp_in = sp_cur + SP_W'(1);
            end
            pc_in = target;
         end
         vgis_pkg::OP_RET: begin
            if (sp_cur == '0 || sp_cur > SP_W'(STACK_DEPTH)) begin
               status = vgis_pkg::ST_UNDERFLOW;
            end else begin
               sp_in = sp_cur - SP_W'(1);
               pc_in = pop_data;
            end
         end
         vgis_pkg::OP_JUMP: begin
            pc_in = target;
         end
         default: begin
            status = vgis_pkg::ST_RUN;
         end
      endcase
      flow.next_address = pc_in;
      flow.status       = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= vgis_pkg::VEC_BASE;
         sp_ff <= '0;
      end else if (exec) begin
         pc_ff <= pc_in;
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec && push) begin
         stack_mem[sp_cur[IDX_W-1:0]] <= pc_adv;
      end
   end

endmodule

@@ rtl/core/vgis_beam.sv @@
// Beam position, global scale and vector delta arithmetic.
`timescale 1ns / 1ps

module vgis_beam #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               exec,
   input  vgis_pkg::req_type  req,
   output vgis_pkg::draw_type seg
);

   localparam int WIDE_W = vgis_pkg::BEAM_W + vgis_pkg::COORD_W;

   logic [vgis_pkg::BEAM_W-1:0] beam_x_ff, beam_x_in;
   logic [vgis_pkg::BEAM_W-1:0] beam_y_ff, beam_y_in;
   logic [3:0]                  scale_ff, scale_in;

   logic [15:0] fw, sw;
   logic [3:0]  opcode, scale_cur, scale_sum, shift, z;
   logic        vec, is_abs;
   logic [9:0]  mag_x, mag_y;
   logic signed [vgis_pkg::RAW_W-1:0]  raw_x, raw_y;
   logic signed [vgis_pkg::BEAM_W-1:0] wide_x, wide_y, dx, dy, abs_x, abs_y;
   logic [vgis_pkg::BEAM_W-1:0] nx, ny;
   logic [WIDE_W-1:0] ext_bx, ext_by, ext_nx, ext_ny;

   assign fw     = req.first_word;
   assign sw     = req.second_word;
   assign opcode = fw[15:12];

   always_comb begin
      scale_cur = req.new_frame ? '0 : scale_ff;
      vec    = 1'b0;
      is_abs = 1'b0;
      z      = '0;
      mag_x  = '0;
      mag_y  = '0;
      raw_x  = '0;
      raw_y  = '0;
      scale_sum = scale_cur;
      case (opcode) inside
         vgis_pkg::OP_SHORT: begin
            vec   = 1'b1;
            z     = fw[7:4];
            mag_y = {fw[9:8], 8'h00};
            mag_x = {fw[1:0], 8'h00};
            raw_y = fw[10] ? $signed({1'b0, mag_y}) : -$signed({1'b0, mag_y});
            raw_x = fw[2]  ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
            scale_sum = scale_cur + vgis_pkg::SHORT_SCALE_BIAS
                      + {2'b00, fw[3], 1'b0} + {3'b000, fw[11]};
         end
         [vgis_pkg::OP_LONG_FIRST:vgis_pkg::OP_LONG_LAST]: begin
            vec   = 1'b1;
            z     = sw[15:12];
            mag_y = fw[9:0];
            mag_x = sw[9:0];
            raw_y = fw[10] ? $signed({1'b0, mag_y}) : -$signed({1'b0, mag_y});
            raw_x = sw[10] ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
            scale_sum = scale_cur + opcode;
         end
         vgis_pkg::OP_ABS: begin
            is_abs = 1'b1;
         end
         default: begin
            vec = 1'b0;
         end
      endcase

      // scales above nine behave as minus one
      shift = (scale_sum > vgis_pkg::MAX_SCALE) ? vgis_pkg::MAX_SCALE + 4'd1
                                                : vgis_pkg::MAX_SCALE - scale_sum;
      wide_x = vgis_pkg::BEAM_W'(raw_x) <<< FRACTION_BITS;
      wide_y = vgis_pkg::BEAM_W'(raw_y) <<< FRACTION_BITS;
      dx = wide_x >>> shift;
      dy = wide_y >>> shift;
      nx = beam_x_ff + dx;
      ny = beam_y_ff - dy;

      abs_x = vgis_pkg::BEAM_W'($signed(sw[vgis_pkg::ABS_W-1:0])) <<< FRACTION_BITS;
      abs_y = (vgis_pkg::BEAM_W'($signed(fw[vgis_pkg::ABS_W-1:0]))
               - vgis_pkg::BEAM_W'(vgis_pkg::ABS_Y_FLIP)
               + vgis_pkg::BEAM_W'(vgis_pkg::ABS_Y_ORIGIN)) <<< FRACTION_BITS;

      beam_x_in = beam_x_ff;
      beam_y_in = beam_y_ff;
      scale_in  = scale_cur;
      if (vec) begin
         beam_x_in = nx;
         beam_y_in = ny;
      end else if (is_abs) begin
         beam_x_in = abs_x;
         beam_y_in = abs_y;
         scale_in  = sw[15:12];
      end

      ext_bx = {{vgis_pkg::COORD_W{1'b0}}, beam_x_ff};
      ext_by = {{vgis_pkg::COORD_W{1'b0}}, beam_y_ff};
      ext_nx = {{vgis_pkg::COORD_W{1'b0}}, nx};
      ext_ny = {{vgis_pkg::COORD_W{1'b0}}, ny};

      seg = '0;
      if (vec && z != '0) begin
         seg.draw       = 1'b1;
         seg.point_only = (dx == '0) && (dy == '0);
         seg.start_x    = ext_bx[FRACTION_BITS +: vgis_pkg::COORD_W];
         seg.start_y    = ext_by[FRACTION_BITS +: vgis_pkg::COORD_W];
         seg.end_x      = ext_nx[FRACTION_BITS +: vgis_pkg::COORD_W];
         seg.end_y      = ext_ny[FRACTION_BITS +: vgis_pkg::COORD_W];
         seg.intensity  = {z, vgis_pkg::INTENSITY_LOW};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_x_ff <= '0;
         beam_y_ff <= '0;
         scale_ff  <= '0;
      end else if (exec) begin
         beam_x_ff <= beam_x_in;
         beam_y_ff <= beam_y_in;
         scale_ff  <= scale_in;
      end
   end

endmodule

@@ rtl/core/vgis_checker.sv @@
// Port-level checks for the vector generator instruction step, bound to the top.
`timescale 1ns / 1ps

module vgis_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input vgis_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_quiet_when_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.draw |-> !rsp_data.point_only && rsp_data.intensity == 8'h00
         && rsp_data.start_x == '0 && rsp_data.start_y == '0
         && rsp_data.end_x == '0 && rsp_data.end_y == '0)
      else $error("segment fields set without draw");

   a_intensity_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.draw |->
         rsp_data.intensity[3:0] == vgis_pkg::INTENSITY_LOW && rsp_data.status == vgis_pkg::ST_RUN)
      else $error("bad intensity or status on a drawn segment");

   a_point_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.point_only |->
         rsp_data.start_x == rsp_data.end_x && rsp_data.start_y == rsp_data.end_y)
      else $error("point moved the beam");

   a_even_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.next_address[0])
      else $error("odd fetch address");

endmodule

bind vector_generator_instruction_step vgis_checker u_vgis_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

@@ dv/tb_vector_generator_instruction_step.sv @@
// Self-checking testbench for the vector generator instruction step.
`timescale 1ns / 1ps

module tb_vector_generator_instruction_step;

   localparam int STACK_DEPTH   = 4;
   localparam int FRACTION_BITS = 16;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 305;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   vgis_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   vgis_pkg::rsp_type rsp_data;

   vector_generator_instruction_step #(
      .STACK_DEPTH  (STACK_DEPTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // predictor state
   logic [15:0] pc = vgis_pkg::VEC_BASE;
   logic [15:0] ret_stack [STACK_DEPTH];
   int          sp = 0;
   logic [3:0]  gscale = '0;
   logic [31:0] beam_x = '0;
   logic [31:0] beam_y = '0;

   vgis_pkg::req_type pending [$];
   vgis_pkg::rsp_type expected [$];

   int  errors = 0;
   int  n_req = 0;
   int  n_rsp = 0;
   int  n_draw = 0;
   int  n_overflow = 0;
   int  n_underflow = 0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  send_idle = 1'b1;
   bit  recv_idle = 1'b1;
   logic              drv_valid;
   vgis_pkg::req_type drv_data;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint scaled_delta(longint raw, int scale);
      longint wide;
      wide = raw * (longint'(1) << FRACTION_BITS);
      return wide >>> (9 - scale);
   endfunction

   // scale sums above nine act as minus one
   function automatic int eff_scale(logic [3:0] s);
      return (s > vgis_pkg::MAX_SCALE) ? -1 : int'(s);
   endfunction

   function automatic vgis_pkg::rsp_type predict_step(vgis_pkg::req_type r);
      vgis_pkg::rsp_type o;
      logic [3:0]  op;
      logic [3:0]  z;
      logic [3:0]  sc_sum;
      logic [15:0] fw;
      logic [15:0] sw;
      logic [15:0] target;
      longint      x;
      longint      y;
      longint      dx;
      longint      dy;
      longint      ax;
      longint      ay;
      logic [31:0] nx;
      logic [31:0] ny;
      bit          vec;
      o = '0;
      o.status = vgis_pkg::ST_RUN;
      vec = 1'b0;
      z = '0;
      dx = 0;
      dy = 0;
      fw = r.first_word;
      sw = r.second_word;
      op = fw[15:12];
      target = vgis_pkg::VEC_BASE + {fw[12:0], 1'b0};
      if (r.new_frame) begin
         pc = vgis_pkg::VEC_BASE;
         sp = 0;
         gscale = '0;
      end
      pc = pc + vgis_pkg::WORD_BYTES;
      if (op <= vgis_pkg::OP_ABS) pc = pc + vgis_pkg::WORD_BYTES;
      case (op)
         vgis_pkg::OP_SHORT: begin
            z = fw[7:4];
            y = longint'({fw[9:8], 8'h00});
            x = longint'({fw[1:0], 8'h00});
            if (fw[10]) y = -y;
            if (fw[2]) x = -x;
            y = -y;
            sc_sum = gscale + vgis_pkg::SHORT_SCALE_BIAS + {2'b00, fw[3], 1'b0}
                   + {3'b000, fw[11]};
            dx = scaled_delta(x, eff_scale(sc_sum));
            dy = scaled_delta(y, eff_scale(sc_sum));
            vec = 1'b1;
         end
         vgis_pkg::OP_ABS: begin
            ax = longint'($signed(sw[11:0]));
            ay = vgis_pkg::ABS_Y_FLIP - longint'($signed(fw[11:0]));
            gscale = sw[15:12];
            beam_y = 32'((vgis_pkg::ABS_Y_ORIGIN - ay) * (longint'(1) << FRACTION_BITS));
            beam_x = 32'(ax * (longint'(1) << FRACTION_BITS));
         end
         vgis_pkg::OP_HALT0, vgis_pkg::OP_HALT1: o.status = vgis_pkg::ST_HALT;
         vgis_pkg::OP_CALL: begin
            // a call onto a full stack flags overflow and resets the pointer without writing
            if (sp >= STACK_DEPTH) begin
               o.status = vgis_pkg::ST_OVERFLOW;
               sp = 0;
            end else begin
               ret_stack[sp] = pc;
               sp++;
            end
            pc = target;
         end
         vgis_pkg::OP_RET: begin
            if (sp == 0) begin
               o.status = vgis_pkg::ST_UNDERFLOW;
            end else begin
               sp--;
               pc = ret_stack[sp];
            end
         end
         vgis_pkg::OP_JUMP: pc = target;
         default: begin
            z = sw[15:12];
            y = longint'(fw[9:0]);
            x = longint'(sw[9:0]);
            if (fw[10]) y = -y;
            if (sw[10]) x = -x;
            y = -y;
            sc_sum = gscale + op;
            dx = scaled_delta(x, eff_scale(sc_sum));
            dy = scaled_delta(y, eff_scale(sc_sum));
            vec = 1'b1;
         end
      endcase
      if (vec) begin
         nx = beam_x + 32'(dx);
         ny = beam_y - 32'(dy);
         if (z != 0) begin
            o.draw       = 1'b1;
            o.point_only = (dx == 0 && dy == 0);
            o.start_x    = beam_x[FRACTION_BITS +: vgis_pkg::COORD_W];
            o.start_y    = beam_y[FRACTION_BITS +: vgis_pkg::COORD_W];
            o.end_x      = nx[FRACTION_BITS +: vgis_pkg::COORD_W];
            o.end_y      = ny[FRACTION_BITS +: vgis_pkg::COORD_W];
            o.intensity  = {z, vgis_pkg::INTENSITY_LOW};
         end
         beam_x = nx;
         beam_y = ny;
      end
      o.next_address = pc;
      return o;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         errors++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // request side acceptance and result checking
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            n_rsp++;
            if (n_rsp == 300 || n_rsp == 1000) hold_request = 1'b1;
            if (expected.size() == 0) begin
               errors++;
               $display("%0t unexpected result: expected none actual %h", $time, rsp_data);
            end else begin
               vgis_pkg::rsp_type want;
               want = expected.pop_front();
               check_field("next_address", want.next_address, rsp_data.next_address);
               check_field("draw", want.draw, rsp_data.draw);
               check_field("point_only", want.point_only, rsp_data.point_only);
               check_field("start_x", want.start_x, rsp_data.start_x);
               check_field("start_y", want.start_y, rsp_data.start_y);
               check_field("end_x", want.end_x, rsp_data.end_x);
               check_field("end_y", want.end_y, rsp_data.end_y);
               check_field("intensity", want.intensity, rsp_data.intensity);
               check_field("status", want.status, rsp_data.status);
            end
         end
         if (req_valid && !req_stall) begin
            vgis_pkg::rsp_type pred;
            pred = predict_step(req_data);
            expected.push_back(pred);
            req_taken = 1'b1;
            n_req++;
            if (pred.draw) n_draw++;
            if (pred.status == vgis_pkg::ST_OVERFLOW) n_overflow++;
            if (pred.status == vgis_pkg::ST_UNDERFLOW) n_underflow++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      drv_valid = req_valid;
      drv_data  = req_data;
      if (req_taken) drv_valid = 1'b0;
      req_taken = 1'b0;
      if (!reset && !drv_valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending.size() != 0) begin
            drv_data  = pending.pop_front();
            drv_valid = 1'b1;
            // keep offering back to back while the receiver holds off or the sender is not idle
            send_gap  = (send_idle && hold_left == 0) ? $urandom_range(0, 12) : 0;
            if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
         end
      end
      req_valid <= drv_valid;
      req_data  <= drv_data;
   end

   // result receiver
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         recv_gap  = recv_idle ? $urandom_range(0, 12) : 0;
         if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic add_req(logic [15:0] fw, logic [15:0] sw, logic nf);
      vgis_pkg::req_type r;
      r.first_word  = fw;
      r.second_word = sw;
      r.new_frame   = nf;
      pending.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending.size() != 0 || req_valid || expected.size() != 0) @(posedge clock);
   endtask

   function automatic vgis_pkg::req_type rand_item();
      vgis_pkg::req_type r;
      int                pick;
      r.first_word  = 16'($urandom);
      r.second_word = 16'($urandom);
      r.new_frame   = ($urandom_range(0, 19) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.first_word[15:12] = 4'($urandom_range(1, 9));
      else if (pick < 60) r.first_word[15:12] = vgis_pkg::OP_SHORT;
      else if (pick < 68) r.first_word[15:12] = vgis_pkg::OP_ABS;
      else if (pick < 77) r.first_word[15:12] = vgis_pkg::OP_CALL;
      else if (pick < 87) r.first_word[15:12] = vgis_pkg::OP_RET;
      else if (pick < 91) r.first_word[15:12] = vgis_pkg::OP_JUMP;
      else if (pick < 95) r.first_word[15:12] = $urandom_range(0, 1) ? vgis_pkg::OP_HALT0
                                                                    : vgis_pkg::OP_HALT1;
      return r;
   endfunction

   // long full-length moves in one direction, enough to wrap the beam
   task automatic add_beam_run();
      logic sx;
      logic sy;
      sx = 1'($urandom);
      sy = 1'($urandom);
      add_req({vgis_pkg::OP_ABS, 12'h000}, 16'h0000, 1'b0);
      repeat (70) add_req({vgis_pkg::OP_LONG_LAST, 1'b0, sy, 10'h3ff},
                          {4'($urandom), 1'b0, sx, 10'h3ff}, 1'b0);
   endtask

   initial begin
      int n;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, each instruction kind, stack and scale corner cases
      add_req({vgis_pkg::OP_LONG_LAST, 12'h3ff}, 16'hf3ff, 1'b0);
      add_req({vgis_pkg::OP_LONG_FIRST, 12'h7ff}, 16'hf7ff, 1'b0);
      add_req(16'h5000, 16'h8000, 1'b0);
      add_req(16'h3123, 16'h0456, 1'b0);
      add_req(16'hffff, 16'hffff, 1'b0);
      add_req({vgis_pkg::OP_SHORT, 12'h000}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_SHORT, 12'h0f0}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_ABS, 12'hfff}, 16'hffff, 1'b0);
      add_req({vgis_pkg::OP_LONG_LAST, 12'h155}, 16'h52aa, 1'b0);
      add_req({vgis_pkg::OP_ABS, 12'h800}, 16'h1800, 1'b0);
      add_req({vgis_pkg::OP_LONG_LAST, 12'h7ff}, 16'hc3ff, 1'b0);
      add_req({vgis_pkg::OP_ABS, 12'h7ff}, 16'h07ff, 1'b0);
      add_req({vgis_pkg::OP_HALT0, 12'h000}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_HALT1, 12'hfff}, 16'hffff, 1'b0);
      add_req({vgis_pkg::OP_RET, 12'h000}, 16'h0000, 1'b1);
      add_req({vgis_pkg::OP_CALL, 12'h123}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_CALL, 12'hfff}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_CALL, 12'h000}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_CALL, 12'h555}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_CALL, 12'h777}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_CALL, 12'h010}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_RET, 12'hfff}, 16'hffff, 1'b0);
      add_req({vgis_pkg::OP_RET, 12'h000}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_JUMP, 12'hfff}, 16'h0000, 1'b0);
      add_req({vgis_pkg::OP_JUMP, 12'h000}, 16'hffff, 1'b1);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         n = 0;
         while (n < PHASE_ITEMS) begin
            if ($urandom_range(0, 149) == 0) begin
               add_beam_run();
               n += 71;
            end else begin
               pending.push_back(rand_item());
               n++;
            end
         end
         wait_drained();
      end
      repeat (8) @(posedge clock);

      $display("run covered %0d requests and %0d results: %0d drawn, %0d overflow, %0d underflow",
               n_req, n_rsp, n_draw, n_overflow, n_underflow);
      if (errors == 0 && expected.size() == 0)
         $display("vector_generator_instruction_step verification clean");
      else
         $display("vector_generator_instruction_step verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("vector_generator_instruction_step verification failed");
      $finish;
   end

endmodule
